// ===== design/hcpu_pkg.sv =====
package hcpu_pkg;

   localparam int unsigned WordWidth = 16;
   localparam int unsigned CompWidth = 7;
   localparam int unsigned DestWidth = 3;
   localparam int unsigned JumpWidth = 3;

   typedef logic [WordWidth-1:0] word_type;

   // compute codes, low six bits (bit six picks M over A)
   localparam logic [5:0] CompDAndY   = 6'h00;
   localparam logic [5:0] CompDPlusY  = 6'h02;
   localparam logic [5:0] CompYMinusD = 6'h07;
   localparam logic [5:0] CompDMinusY = 6'h13;
   localparam logic [5:0] CompDOrY    = 6'h15;
   localparam logic [5:0] CompY       = 6'h30;
   localparam logic [5:0] CompNotY    = 6'h31;
   localparam logic [5:0] CompYDec    = 6'h32;
   localparam logic [5:0] CompYNeg    = 6'h33;
   localparam logic [5:0] CompYInc    = 6'h37;
   // only valid with bit six clear
   localparam logic [5:0] CompD       = 6'h0c;
   localparam logic [5:0] CompNotD    = 6'h0d;
   localparam logic [5:0] CompDDec    = 6'h0e;
   localparam logic [5:0] CompDNeg    = 6'h0f;
   localparam logic [5:0] CompDInc    = 6'h1f;
   localparam logic [5:0] CompZero    = 6'h2a;
   localparam logic [5:0] CompOnes    = 6'h3a;
   localparam logic [5:0] CompOne     = 6'h3f;

   // destination and jump bit positions
   localparam int unsigned DestM   = 0;
   localparam int unsigned DestD   = 1;
   localparam int unsigned DestA   = 2;
   localparam int unsigned JumpPos = 0;
   localparam int unsigned JumpZer = 1;
   localparam int unsigned JumpNeg = 2;

   typedef struct packed {
      word_type next_pc;
      word_type a_value;
      word_type d_value;
      logic     mem_write_enable;
      word_type mem_write_address;
      word_type mem_write_data;
      logic     stopped;
      logic     bad_comp;
   } result_type;

   typedef struct packed {
      word_type instruction;
      word_type mem_read_data;
      logic     breakpoint_hit;
   } word_in_type;

endpackage

// ===== design/hack_cpu_instruction_step.sv =====
// an accepted word goes through the input register, then the result register
// throughput: one instruction word per cycle unless the result side stalls; the execute
// step reads A, D and PC as left by the previous word, fed back from the state registers
// a waiting result stalls req_ready only once the input register also holds a word
// reset (synchronous, active high): PC, A, D and stop_on_breakpoint cleared,
// both stages emptied
module hack_cpu_instruction_step (
   input  logic               clock,
   input  logic               reset,
   // instruction word channel
   input  logic               req_valid,
   output logic               req_ready,
   input  hcpu_pkg::word_type req_instruction,
   input  hcpu_pkg::word_type req_mem_read_data,
   input  logic               req_breakpoint_hit,
   // step result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hcpu_pkg::word_type rsp_next_pc,
   output hcpu_pkg::word_type rsp_a_value,
   output hcpu_pkg::word_type rsp_d_value,
   output logic               rsp_mem_write_enable,
   output hcpu_pkg::word_type rsp_mem_write_address,
   output hcpu_pkg::word_type rsp_mem_write_data,
   output logic               rsp_stopped,
   output logic               rsp_bad_comp,
   // configuration
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   hcpu_pkg::word_in_type in_word_ff;

   // architectural state
   hcpu_pkg::word_type    pc_ff;
   hcpu_pkg::word_type    a_ff;
   hcpu_pkg::word_type    d_ff;
   logic                  stop_ff;

   // result stage
   logic                  out_valid_ff;
   logic                  out_valid_in;
   hcpu_pkg::result_type  out_ff;
   hcpu_pkg::result_type  out_in;

   logic                  req_accept;
   logic                  advance;

   // execute moves the buffered word into the result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   hcpu_exec u_exec (
      .word_in            (in_word_ff),
      .stop_on_breakpoint (stop_ff),
      .pc                 (pc_ff),
      .a_reg              (a_ff),
      .d_reg              (d_ff),
      .result             (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         a_ff         <= '0;
         d_ff         <= '0;
         stop_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            stop_ff <= csr_write_data;
         end
         // state commits when the word is executed
         if (advance) begin
            pc_ff <= out_in.next_pc;
            a_ff  <= out_in.a_value;
            d_ff  <= out_in.d_value;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff.instruction    <= req_instruction;
         in_word_ff.mem_read_data  <= req_mem_read_data;
         in_word_ff.breakpoint_hit <= req_breakpoint_hit;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_next_pc           = out_ff.next_pc;
   assign rsp_a_value           = out_ff.a_value;
   assign rsp_d_value           = out_ff.d_value;
   assign rsp_mem_write_enable  = out_ff.mem_write_enable;
   assign rsp_mem_write_address = out_ff.mem_write_address;
   assign rsp_mem_write_data    = out_ff.mem_write_data;
   assign rsp_stopped           = out_ff.stopped;
   assign rsp_bad_comp          = out_ff.bad_comp;

   // a shown result always matches the committed state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_pc == pc_ff && rsp_a_value == a_ff && rsp_d_value == d_ff))
      else $error("result word differs from committed state");

   // a halted step writes nothing and flags nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stopped) |-> (!rsp_mem_write_enable && !rsp_bad_comp))
      else $error("stopped step has side effects");

   // a bad compute code, unlisted or an A-only form with bit six set, yields zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_comp) |-> (rsp_mem_write_data == 16'd0))
      else $error("bad compute code with nonzero result");

   // a stall of the result side holds the state registers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(pc_ff) && $stable(a_ff) && $stable(d_ff)))
      else $error("state changed while result stalled");

   // input side only backs up when both stages are full and the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

endmodule

// ===== design/hcpu_alu.sv =====
module hcpu_alu (
   input  logic [hcpu_pkg::CompWidth-1:0] comp,
   input  hcpu_pkg::word_type             d_value,
   input  hcpu_pkg::word_type             a_value,
   input  hcpu_pkg::word_type             m_value,
   output hcpu_pkg::word_type             result,
   output logic                           bad
);

   hcpu_pkg::word_type y;
   logic               use_m;

   assign use_m = comp[hcpu_pkg::CompWidth-1];
   assign y     = use_m ? m_value : a_value;

   always_comb begin
      bad = 1'b0;
      unique case (comp[5:0])
         hcpu_pkg::CompDAndY:   result = d_value & y;
         hcpu_pkg::CompDPlusY:  result = d_value + y;
         hcpu_pkg::CompYMinusD: result = y - d_value;
         hcpu_pkg::CompDMinusY: result = d_value - y;
         hcpu_pkg::CompDOrY:    result = d_value | y;
         hcpu_pkg::CompY:       result = y;
         hcpu_pkg::CompNotY:    result = ~y;
         hcpu_pkg::CompYDec:    result = y - 16'd1;
         hcpu_pkg::CompYNeg:    result = 16'd0 - y;
         hcpu_pkg::CompYInc:    result = y + 16'd1;
         // d-only and constant forms exist only with the a-operand
         hcpu_pkg::CompD:       result = use_m ? 16'd0 : d_value;
         hcpu_pkg::CompNotD:    result = use_m ? 16'd0 : ~d_value;
         hcpu_pkg::CompDDec:    result = use_m ? 16'd0 : d_value - 16'd1;
         hcpu_pkg::CompDNeg:    result = use_m ? 16'd0 : 16'd0 - d_value;
         hcpu_pkg::CompDInc:    result = use_m ? 16'd0 : d_value + 16'd1;
         hcpu_pkg::CompZero:    result = 16'd0;
         hcpu_pkg::CompOnes:    result = use_m ? 16'd0 : 16'hffff;
         hcpu_pkg::CompOne:     result = use_m ? 16'd0 : 16'd1;
         default: begin
            result = 16'd0;
            bad    = 1'b1;
         end
      endcase
      if (use_m && (comp[5:0] == hcpu_pkg::CompD || comp[5:0] == hcpu_pkg::CompNotD ||
                    comp[5:0] == hcpu_pkg::CompDDec || comp[5:0] == hcpu_pkg::CompDNeg ||
                    comp[5:0] == hcpu_pkg::CompDInc || comp[5:0] == hcpu_pkg::CompZero ||
                    comp[5:0] == hcpu_pkg::CompOnes || comp[5:0] == hcpu_pkg::CompOne)) begin
         bad = 1'b1;
      end
   end

endmodule

// ===== design/hcpu_exec.sv =====
module hcpu_exec (
   input  hcpu_pkg::word_in_type word_in,
   input  logic                  stop_on_breakpoint,
   input  hcpu_pkg::word_type    pc,
   input  hcpu_pkg::word_type    a_reg,
   input  hcpu_pkg::word_type    d_reg,
   output hcpu_pkg::result_type  result
);

   hcpu_pkg::word_type                alu_result;
   logic                              alu_bad;
   logic [hcpu_pkg::DestWidth-1:0]    dest;
   logic [hcpu_pkg::JumpWidth-1:0]    jump;
   logic                              is_c;
   logic                              neg;
   logic                              zero;
   logic                              take;
   hcpu_pkg::word_type                pc_inc;

   assign is_c   = word_in.instruction[15];
   assign dest   = word_in.instruction[5:3];
   assign jump   = word_in.instruction[2:0];
   assign pc_inc = pc + 16'd1;

   hcpu_alu u_alu (
      .comp    (word_in.instruction[12:6]),
      .d_value (d_reg),
      .a_value (a_reg),
      .m_value (word_in.mem_read_data),
      .result  (alu_result),
      .bad     (alu_bad)
   );

   assign neg  = alu_result[15];
   assign zero = (alu_result == 16'd0);
   assign take = (jump[hcpu_pkg::JumpNeg] && neg) || (jump[hcpu_pkg::JumpZer] && zero) ||
                 (jump[hcpu_pkg::JumpPos] && !neg && !zero);

   always_comb begin
      result.next_pc           = pc;
      result.a_value           = a_reg;
      result.d_value           = d_reg;
      result.mem_write_enable  = 1'b0;
      result.mem_write_address = a_reg;
      result.mem_write_data    = 16'd0;
      result.stopped           = 1'b0;
      result.bad_comp          = 1'b0;
      priority if (stop_on_breakpoint && word_in.breakpoint_hit) begin
         result.stopped = 1'b1;
      end else if (!is_c) begin
         result.a_value = {1'b0, word_in.instruction[14:0]};
         result.next_pc = pc_inc;
      end else begin
         result.bad_comp         = alu_bad;
         result.mem_write_data   = alu_result;
         result.mem_write_enable = dest[hcpu_pkg::DestM];
         if (dest[hcpu_pkg::DestD]) begin
            result.d_value = alu_result;
         end
         if (dest[hcpu_pkg::DestA]) begin
            result.a_value = alu_result;
         end
         // jump goes to the A value from before this write
         result.next_pc = take ? a_reg : pc_inc;
      end
   end

endmodule
